>>> hdl/bsa_pkg.sv
// shared types and constants for the bubble sort block
// no dependencies; used by bsa_ctrl, bsa_dpath and bubble_sort_ascending_top
package bsa_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int VAL_W     = 32;

	// sorter control states, one-hot
	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_INIT  = 6'b000010,
		ST_FIRST = 6'b000100,
		ST_RUN   = 6'b001000,
		ST_END   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	// source of the store write data
	typedef enum logic [1:0] {
		SRC_IN    = 2'd0,
		SRC_LOW   = 2'd1,
		SRC_CARRY = 2'd2
	} wr_src_t;

	typedef struct packed {
		logic    wr_en;
		wr_src_t wr_src;
		logic    rd_en;
		logic    carry_first;
		logic    carry_step;
	} dp_cmd_t;

endpackage

>>> hdl/bsa_dpath.sv
// datapath of the bubble sort: element store, carry register and compare
// depends on bsa_pkg; driven by bsa_ctrl
module bsa_dpath #(
	parameter int DEPTH = bsa_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                            clk,
	input  bsa_pkg::dp_cmd_t                cmd,
	input  logic [AW-1:0]                   wr_addr,
	input  logic [AW-1:0]                   rd_addr,
	input  logic signed [bsa_pkg::VAL_W-1:0] value,
	output logic                            swap,
	output logic signed [bsa_pkg::VAL_W-1:0] rd_data
);
	import bsa_pkg::*;

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rd_data_q;
	logic signed [VAL_W-1:0] carry_q;
	logic signed [VAL_W-1:0] wr_data;

	// carry holds the largest element seen so far in the current pass
	assign swap = carry_q > rd_data_q;

	always_comb begin
		case (cmd.wr_src)
			SRC_IN:    wr_data = value;
			SRC_LOW:   wr_data = swap ? rd_data_q : carry_q;
			SRC_CARRY: wr_data = carry_q;
			default:   wr_data = carry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.carry_first) begin
			carry_q <= rd_data_q;
		end else if (cmd.carry_step && !swap) begin
			carry_q <= rd_data_q;
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/bsa_ctrl.sv
// controller of the bubble sort: load, sort passes and emit sequencing
// depends on bsa_pkg; commands bsa_dpath
module bsa_ctrl #(
	parameter int DEPTH = bsa_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             last_item,
	input  logic             swap,
	output logic             busy,
	output bsa_pkg::dp_cmd_t cmd,
	output logic [AW-1:0]    wr_addr,
	output logic [AW-1:0]    rd_addr,
	output logic             result_strobe,
	output logic             last_result,
	output logic             overflow
);
	import bsa_pkg::*;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] end_q;
	logic [CW-1:0] idx_q;
	logic          swapped_q;
	logic          strobe_q;
	logic          last_q;
	logic          ovf_out_q;

	logic          accept;
	logic          room;
	logic [CW-1:0] count_nxt;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] idx_dec;
	logic [CW-1:0] end_dec;
	logic [CW-1:0] count_dec;

	assign accept    = start && (state_q == ST_LOAD);
	assign room      = count_q < CW'(DEPTH);
	assign count_nxt = room ? count_q + CW'(1) : count_q;
	assign idx_inc   = idx_q + CW'(1);
	assign idx_dec   = idx_q - CW'(1);
	assign end_dec   = end_q - CW'(1);
	assign count_dec = count_q - CW'(1);

	always_comb begin
		cmd     = '0;
		cmd.wr_src = SRC_IN;
		wr_addr = count_q[AW-1:0];
		rd_addr = idx_q[AW-1:0];
		case (state_q)
			ST_LOAD: begin
				cmd.wr_en = accept && room;
			end
			ST_INIT: begin
				cmd.rd_en = 1'b1;
				rd_addr   = '0;
			end
			ST_FIRST: begin
				cmd.rd_en       = 1'b1;
				cmd.carry_first = 1'b1;
				rd_addr         = AW'(1);
			end
			ST_RUN: begin
				// the smaller of carry and the new element settles one slot back
				cmd.wr_en      = 1'b1;
				cmd.wr_src     = SRC_LOW;
				cmd.carry_step = 1'b1;
				wr_addr        = idx_dec[AW-1:0];
				cmd.rd_en      = idx_inc < end_q;
				rd_addr        = idx_inc[AW-1:0];
			end
			ST_END: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = SRC_CARRY;
				wr_addr    = end_dec[AW-1:0];
			end
			ST_EMIT: begin
				cmd.rd_en = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			end_q     <= '0;
			idx_q     <= '0;
			swapped_q <= 1'b0;
			strobe_q  <= 1'b0;
			last_q    <= 1'b0;
			ovf_out_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						count_q <= count_nxt;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (last_item) begin
							end_q <= count_nxt;
							idx_q <= '0;
							state_q <= (count_nxt > CW'(1)) ? ST_INIT : ST_EMIT;
						end
					end
				end
				ST_INIT: begin
					swapped_q <= 1'b0;
					state_q   <= ST_FIRST;
				end
				ST_FIRST: begin
					idx_q   <= CW'(1);
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					swapped_q <= swapped_q | swap;
					if (idx_inc < end_q) begin
						idx_q <= idx_inc;
					end else begin
						state_q <= ST_END;
					end
				end
				ST_END: begin
					end_q <= end_dec;
					idx_q <= '0;
					// another pass only if this one moved something
					if (swapped_q && end_dec > CW'(1)) begin
						state_q <= ST_INIT;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					strobe_q  <= 1'b1;
					last_q    <= idx_q == count_dec;
					ovf_out_q <= ovf_q;
					if (idx_q == count_dec) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						idx_q <= idx_inc;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign busy          = state_q != ST_LOAD;
	assign result_strobe = strobe_q;
	assign last_result   = last_q;
	assign overflow      = ovf_out_q;

endmodule

>>> hdl/bubble_sort_ascending_top.sv
// bubble sort top level: loads one element per cycle while busy is low;
// after the final element sorts by passes over a store with one write and
// one read port (a one-element list skips the passes); results then stream
// one per cycle, each with its strobe once the emit state has read it into
// the read-data register.
// the receiver cannot stall; arst_n clears all control state, store is unreset.
// depends on bsa_pkg, bsa_ctrl and bsa_dpath
module bubble_sort_ascending_top #(
	parameter int DEPTH = bsa_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [bsa_pkg::VAL_W-1:0] value,
	input  logic                             last_item,
	output logic                             result_strobe,
	output logic signed [bsa_pkg::VAL_W-1:0] sorted_value,
	output logic                             last_result,
	output logic                             overflow
);
	import bsa_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	dp_cmd_t       cmd;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          swap;

	bsa_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.last_item    (last_item),
		.swap         (swap),
		.busy         (busy),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr),
		.result_strobe(result_strobe),
		.last_result  (last_result),
		.overflow     (overflow)
	);

	bsa_dpath #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_dpath (
		.clk    (clk),
		.cmd    (cmd),
		.wr_addr(wr_addr),
		.rd_addr(rd_addr),
		.value  (value),
		.swap   (swap),
		.rd_data(sorted_value)
	);

endmodule
